[hw/rtl/bel_pkg.sv]
// Shared types, constants and register codes for the beam event latch.
package bel_pkg;

  localparam int Channels = 3;
  localparam int NumCh    = (Channels > 3) ? 3 : Channels;
  localparam int PinRegs  = 3;

  localparam logic [7:0]  NONE_FOUND     = 8'hFF;
  localparam logic [15:0] LOCKOUT_RST    = 16'd2;
  localparam logic        POLARITY_RST   = 1'b1;
  localparam logic [15:0] PIN_MATCH0_RST = 16'd4;
  localparam logic [15:0] PIN_MATCH1_RST = 16'd2;
  localparam logic [15:0] PIN_MATCH2_RST = 16'd1;

  typedef enum logic [1:0] {
    OP_EVENT       = 2'd0,
    OP_LEVEL       = 2'd1,
    OP_TAKE        = 2'd2,
    OP_TAKE_LOWEST = 2'd3
  } bel_op_e;

  typedef enum logic [2:0] {
    REG_LOCKOUT  = 3'd0,
    REG_POLARITY = 3'd1,
    REG_PIN0     = 3'd2,
    REG_PIN1     = 3'd3,
    REG_PIN2     = 3'd4
  } bel_reg_e;

  typedef struct packed {
    bel_op_e     opcode;
    logic [15:0] pin_mask;
    logic [31:0] now_ms;
    logic        pin_level;
    logic [7:0]  channel;
  } bel_item_t;

  typedef struct packed {
    logic       flag;
    logic [7:0] found_channel;
    logic       event_accepted;
  } bel_result_t;

  typedef struct packed {
    logic [15:0]                    lockout_ms;
    logic                           blocked_polarity;
    logic [PinRegs-1:0][15:0]       pin_match;
  } bel_cfg_t;

endpackage

[hw/rtl/bel_if.sv]
// Channel interfaces: input item, result item and register write.
interface bel_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] pin_mask;
  logic [31:0] now_ms;
  logic        pin_level;
  logic [7:0]  channel;

  modport source (output valid, opcode, pin_mask, now_ms, pin_level, channel, input ready);
  modport sink   (input valid, opcode, pin_mask, now_ms, pin_level, channel, output ready);
endinterface

interface bel_out_if;
  logic       valid;
  logic       ready;
  logic       flag;
  logic [7:0] found_channel;
  logic       event_accepted;

  modport source (output valid, flag, found_channel, event_accepted, input ready);
  modport sink   (input valid, flag, found_channel, event_accepted, output ready);
endinterface

interface bel_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/multi_channel_beam_event_latch_unit.sv]
// A beat passes through 2 register stages: the input register, then the result register.
// Throughput: one item per cycle unless the result stalls; state updates as the item
// leaves the input register, so the next item in that register already sees them.
// A stalled result holds the input register; one more beat then waits there.
// Reset (rst_ni low, async) clears all channel state, valid flags and config to defaults.
// Top level: input register, single-pass core, result register, config registers.
module multi_channel_beam_event_latch_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  bel_in_if.sink     in_i,
  bel_out_if.source  out_o,
  bel_cfg_if.sink    cfg_i
);

  bel_pkg::bel_cfg_t    cfg;
  bel_pkg::bel_item_t   item_q;
  bel_pkg::bel_result_t res_d, res_q;
  logic                 in_vld_q, out_vld_q;
  logic                 adv;

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (adv) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.opcode    <= bel_pkg::bel_op_e'(in_i.opcode);
      item_q.pin_mask  <= in_i.pin_mask;
      item_q.now_ms    <= in_i.now_ms;
      item_q.pin_level <= in_i.pin_level;
      item_q.channel   <= in_i.channel;
    end
    if (adv) res_q <= res_d;
  end

  bel_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bel_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  assign out_o.valid          = out_vld_q;
  assign out_o.flag           = res_q.flag;
  assign out_o.found_channel  = res_q.found_channel;
  assign out_o.event_accepted = res_q.event_accepted;

  property p_adv_fills_out;
    @(posedge clk_i) disable iff (!rst_ni) adv |=> out_vld_q;
  endproperty
  a_adv_fills_out: assert property (p_adv_fills_out) else $error("result beat dropped");

  property p_found_exclusive;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_vld_q && res_q.found_channel != bel_pkg::NONE_FOUND)
      |-> (!res_q.flag && !res_q.event_accepted);
  endproperty
  a_found_exclusive: assert property (p_found_exclusive) else $error("mixed result fields");

  property p_stall_holds_item;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_vld_q && !adv) |=> (in_vld_q && $stable(item_q));
  endproperty
  a_stall_holds_item: assert property (p_stall_holds_item) else $error("stalled item lost");

endmodule

[hw/rtl/bel_cfg_regs.sv]
// Configuration register file: lockout, polarity and per-channel pin masks.
module bel_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  bel_cfg_if.sink         cfg_i,
  output bel_pkg::bel_cfg_t cfg_o
);

  bel_pkg::bel_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lockout_ms       <= bel_pkg::LOCKOUT_RST;
      cfg_q.blocked_polarity <= bel_pkg::POLARITY_RST;
      cfg_q.pin_match[0]     <= bel_pkg::PIN_MATCH0_RST;
      cfg_q.pin_match[1]     <= bel_pkg::PIN_MATCH1_RST;
      cfg_q.pin_match[2]     <= bel_pkg::PIN_MATCH2_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bel_pkg::REG_LOCKOUT:  cfg_q.lockout_ms       <= cfg_i.data;
        bel_pkg::REG_POLARITY: cfg_q.blocked_polarity <= cfg_i.data[0];
        bel_pkg::REG_PIN0:     cfg_q.pin_match[0]     <= cfg_i.data;
        bel_pkg::REG_PIN1:     cfg_q.pin_match[1]     <= cfg_i.data;
        bel_pkg::REG_PIN2:     cfg_q.pin_match[2]     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  property p_reset_lockout;
    @(posedge clk_i) $rose(rst_ni) |-> cfg_q.lockout_ms == bel_pkg::LOCKOUT_RST;
  endproperty
  a_reset_lockout: assert property (p_reset_lockout) else $error("lockout not at reset value");

  property p_bad_index_ignored;
    @(posedge clk_i) disable iff (!rst_ni)
      (cfg_i.valid && cfg_i.index > bel_pkg::REG_PIN2) |=> $stable(cfg_q);
  endproperty
  a_bad_index_ignored: assert property (p_bad_index_ignored) else $error("stray write landed");

  property p_no_write_holds;
    @(posedge clk_i) disable iff (!rst_ni) !cfg_i.valid |=> $stable(cfg_q);
  endproperty
  a_no_write_holds: assert property (p_no_write_holds) else $error("config changed unwritten");

endmodule

[hw/rtl/bel_core.sv]
// Per-channel state and the single-pass result/update logic for one item.
module bel_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  bel_pkg::bel_item_t   item_i,
  input  bel_pkg::bel_cfg_t    cfg_i,
  output bel_pkg::bel_result_t res_o
);

  logic [bel_pkg::NumCh-1:0][31:0] last_q, last_d;
  logic [bel_pkg::NumCh-1:0]       lvl_q, lvl_d;
  logic [bel_pkg::NumCh-1:0]       pend_q, pend_d;

  always_comb begin
    logic        hit;
    logic [31:0] last_sel;
    logic [31:0] elapsed;
    logic        blk;
    int          sel;

    hit      = 1'b0;
    sel      = 0;
    last_sel = '0;
    last_d   = last_q;
    lvl_d    = lvl_q;
    pend_d   = pend_q;
    res_o.flag           = 1'b0;
    res_o.found_channel  = bel_pkg::NONE_FOUND;
    res_o.event_accepted = 1'b0;

    // lowest-numbered exact mask match wins
    for (int i = bel_pkg::NumCh - 1; i >= 0; i--) begin
      if (cfg_i.pin_match[i] == item_i.pin_mask) begin
        hit      = 1'b1;
        sel      = i;
        last_sel = last_q[i];
      end
    end
    elapsed = item_i.now_ms - last_sel;
    blk     = (item_i.pin_level == cfg_i.blocked_polarity);

    case (item_i.opcode)
      bel_pkg::OP_EVENT: begin
        if (hit && (elapsed >= {16'd0, cfg_i.lockout_ms})) begin
          res_o.event_accepted = 1'b1;
          for (int i = 0; i < bel_pkg::NumCh; i++) begin
            if (sel == i) begin
              last_d[i] = item_i.now_ms;
              lvl_d[i]  = blk;
              if (blk) pend_d[i] = 1'b1;
            end
          end
        end
      end
      bel_pkg::OP_LEVEL: begin
        for (int i = 0; i < bel_pkg::NumCh; i++) begin
          if (item_i.channel == 8'(i)) res_o.flag = lvl_q[i];
        end
      end
      bel_pkg::OP_TAKE: begin
        for (int i = 0; i < bel_pkg::NumCh; i++) begin
          if (item_i.channel == 8'(i) && pend_q[i]) begin
            res_o.flag = 1'b1;
            pend_d[i]  = 1'b0;
          end
        end
      end
      bel_pkg::OP_TAKE_LOWEST: begin
        for (int i = bel_pkg::NumCh - 1; i >= 0; i--) begin
          if (pend_q[i]) res_o.found_channel = 8'(i);
        end
        for (int i = 0; i < bel_pkg::NumCh; i++) begin
          if (res_o.found_channel == 8'(i)) pend_d[i] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      lvl_q  <= '0;
      pend_q <= '0;
    end else if (go_i) begin
      last_q <= last_d;
      lvl_q  <= lvl_d;
      pend_q <= pend_d;
    end
  end

  property p_none_means_empty;
    @(posedge clk_i) disable iff (!rst_ni)
      (go_i && item_i.opcode == bel_pkg::OP_TAKE_LOWEST
       && res_o.found_channel == bel_pkg::NONE_FOUND) |-> pend_q == '0;
  endproperty
  a_none_means_empty: assert property (p_none_means_empty) else $error("missed pending latch");

  property p_take_clears_one;
    @(posedge clk_i) disable iff (!rst_ni)
      (go_i && item_i.opcode == bel_pkg::OP_TAKE_LOWEST
       && res_o.found_channel != bel_pkg::NONE_FOUND)
      |=> $countones(pend_q) == $countones($past(pend_q)) - 1;
  endproperty
  a_take_clears_one: assert property (p_take_clears_one) else $error("take did not clear one");

  property p_accept_only_event;
    @(posedge clk_i) disable iff (!rst_ni)
      res_o.event_accepted |-> item_i.opcode == bel_pkg::OP_EVENT;
  endproperty
  a_accept_only_event: assert property (p_accept_only_event) else $error("accept on non-event");

endmodule

[tb/bel_beam_checker.sv]
// Checker for the beam event latch: watches all channels, predicts each result and compares.
module bel_beam_checker
  import bel_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bel_in_if         in_mon,
  bel_out_if        out_mon,
  bel_cfg_if        cfg_mon,
  output int        fail_count,
  output int        due_count,
  output int        results_checked,
  output int        events_taken
);

  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [15:0] lockout;
  logic        polarity;
  logic [15:0] pin_match [PinRegs];

  // per-channel state
  logic [31:0] last_time [NumCh];
  logic        blocked   [NumCh];
  logic        latched   [NumCh];

  bel_result_t due_results [$];

  initial begin
    fail_count      = 0;
    due_count       = 0;
    results_checked = 0;
    events_taken    = 0;
  end

  function automatic void clear_state();
    lockout      = LOCKOUT_RST;
    polarity     = POLARITY_RST;
    pin_match[0] = PIN_MATCH0_RST;
    pin_match[1] = PIN_MATCH1_RST;
    pin_match[2] = PIN_MATCH2_RST;
    for (int c = 0; c < NumCh; c++) begin
      last_time[c] = '0;
      blocked[c]   = 1'b0;
      latched[c]   = 1'b0;
    end
  endfunction

  function automatic void store_register(logic [2:0] idx, logic [15:0] data);
    case (idx)
      REG_LOCKOUT:  lockout      = data;
      REG_POLARITY: polarity     = data[0];
      REG_PIN0:     pin_match[0] = data;
      REG_PIN1:     pin_match[1] = data;
      REG_PIN2:     pin_match[2] = data;
      default: ;
    endcase
  endfunction

  // Updates channel state as the block does and returns the result of this beat.
  function automatic bel_result_t beam_outcome(bel_item_t beat);
    bel_result_t res;
    int          hit;
    logic [31:0] gap;
    logic        blk;
    res.flag           = 1'b0;
    res.found_channel  = NONE_FOUND;
    res.event_accepted = 1'b0;
    hit                = -1;
    case (beat.opcode)
      OP_EVENT: begin
        // scan downward so the lowest matching channel wins
        for (int c = NumCh - 1; c >= 0; c--) begin
          if (pin_match[c] == beat.pin_mask) hit = c;
        end
        if (hit >= 0) begin
          gap = beat.now_ms - last_time[hit];
          if (gap >= {16'h0000, lockout}) begin
            blk            = (beat.pin_level == polarity);
            last_time[hit] = beat.now_ms;
            blocked[hit]   = blk;
            if (blk) latched[hit] = 1'b1;
            res.event_accepted = 1'b1;
          end
        end
      end
      OP_LEVEL: begin
        if (beat.channel < NumCh) res.flag = blocked[beat.channel];
      end
      OP_TAKE: begin
        if (beat.channel < NumCh && latched[beat.channel]) begin
          latched[beat.channel] = 1'b0;
          res.flag              = 1'b1;
        end
      end
      default: begin
        for (int c = 0; c < NumCh; c++) begin
          if (res.found_channel == NONE_FOUND && latched[c]) begin
            latched[c]        = 1'b0;
            res.found_channel = 8'(c);
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bel_item_t   beat;
    bel_result_t got;
    bel_result_t want;
    if (!rst_ni) begin
      clear_state();
      due_results.delete();
      due_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) store_register(cfg_mon.index, cfg_mon.data);
      // results leave before this edge's input beat is predicted
      if (out_mon.valid && out_mon.ready) begin
        got.flag           = out_mon.flag;
        got.found_channel  = out_mon.found_channel;
        got.event_accepted = out_mon.event_accepted;
        if (due_results.size() == 0) begin
          $error("result beat with no prediction outstanding");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          results_checked++;
          if (got.flag !== want.flag) begin
            $error("flag: expected %0d, got %0d", want.flag, got.flag);
            fail_count++;
          end
          if (got.found_channel !== want.found_channel) begin
            $error("found_channel: expected %0d, got %0d", want.found_channel,
                   got.found_channel);
            fail_count++;
          end
          if (got.event_accepted !== want.event_accepted) begin
            $error("event_accepted: expected %0d, got %0d", want.event_accepted,
                   got.event_accepted);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        beat.opcode    = bel_op_e'(in_mon.opcode);
        beat.pin_mask  = in_mon.pin_mask;
        beat.now_ms    = in_mon.now_ms;
        beat.pin_level = in_mon.pin_level;
        beat.channel   = in_mon.channel;
        want           = beam_outcome(beat);
        if (want.event_accepted) events_taken++;
        due_results.push_back(want);
      end
      due_count = due_results.size();
    end
  end

endmodule

[tb/tb_multi_channel_beam_event_latch_unit.sv]
// Testbench top for the beam event latch: stimulus, idling control and verdict.
module tb_multi_channel_beam_event_latch_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import bel_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam logic [2:0] RegSpare = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bel_in_if  in_ch ();
  bel_out_if out_ch ();
  bel_cfg_if cfg_ch ();

  int fail_count;
  int due_cnt;
  int results_checked;
  int events_taken;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          beats_sent     = 0;
  int          settings_used  = 1;
  logic [15:0] cur_lockout    = LOCKOUT_RST;
  logic [15:0] cur_pins [3]   = '{PIN_MATCH0_RST, PIN_MATCH1_RST, PIN_MATCH2_RST};
  logic [31:0] clock_ms       = '0;

  always #4 clk_i = ~clk_i;

  multi_channel_beam_event_latch_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  bel_beam_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_mon         (cfg_ch),
    .fail_count      (fail_count),
    .due_count       (due_cnt),
    .results_checked (results_checked),
    .events_taken    (events_taken)
  );

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 61; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 61; end
      default:   begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // Ready is sampled at the falling edge, so it holds the value seen at the next rising edge.
  task automatic send_beat(bel_op_e op, logic [15:0] mask, logic [31:0] stamp, logic lvl,
                           logic [7:0] ch);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.pin_mask  <= mask;
    in_ch.now_ms    <= stamp;
    in_ch.pin_level <= lvl;
    in_ch.channel   <= ch;
    do begin
      @(negedge clk_i);
      took = in_ch.ready;
      @(posedge clk_i);
    end while (!took);
    beats_sent++;
  endtask

  // Stops sending until every predicted result has come back, then lets the pipe empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (due_cnt != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    logic took;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do begin
      @(negedge clk_i);
      took = cfg_ch.ready;
      @(posedge clk_i);
    end while (!took);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_LOCKOUT: cur_lockout = data;
      REG_PIN0:    cur_pins[0] = data;
      REG_PIN1:    cur_pins[1] = data;
      REG_PIN2:    cur_pins[2] = data;
      default: ;
    endcase
  endtask

  task automatic apply_phase_setting(int p);
    logic [15:0] lk;
    logic [15:0] pins [3];
    case (p)
      0:       lk = 16'h0000;
      1, 7:    lk = 16'hFFFF;
      2:       lk = 16'h0001;
      5:       lk = 16'($urandom);
      default: lk = 16'($urandom_range(2, 40));
    endcase
    for (int c = 0; c < 3; c++) pins[c] = 16'($urandom);
    if (p == 3) begin
      // identical masks: lowest channel must win every time
      pins[1] = pins[0];
      pins[2] = pins[0];
    end
    if (p == 6) begin
      pins[0] = 16'h0000;
      pins[1] = 16'hFFFF;
      pins[2] = 16'h8000;
    end
    write_reg(REG_LOCKOUT, lk);
    write_reg(REG_POLARITY, 16'(p % 2));
    write_reg(REG_PIN0, pins[0]);
    write_reg(REG_PIN1, pins[1]);
    write_reg(REG_PIN2, pins[2]);
    settings_used++;
  endtask

  task automatic random_beat();
    int          pick;
    int          lk;
    bel_op_e     op;
    logic [15:0] mask;
    logic [31:0] stamp;
    logic [7:0]  ch;
    pick = $urandom_range(99);
    lk   = cur_lockout;
    mask = cur_pins[$urandom_range(2)];
    if ($urandom_range(9) < 2) mask = 16'($urandom);
    ch = 8'($urandom_range(NumCh - 1));
    if ($urandom_range(9) == 0) ch = 8'($urandom);
    if (pick < 45) begin
      op = OP_EVENT;
      // time steps cluster around the lockout so both sides of it are hit
      case ($urandom_range(9))
        0, 1, 2: clock_ms += $urandom_range(0, 2 * lk + 2);
        3, 4:    clock_ms += lk;
        5:       clock_ms += lk - 1;
        6:       clock_ms = $urandom;
        default: clock_ms += $urandom_range(0, 3);
      endcase
      stamp = clock_ms;
    end else begin
      if (pick < 60)      op = OP_LEVEL;
      else if (pick < 80) op = OP_TAKE;
      else                op = OP_TAKE_LOWEST;
      stamp = $urandom;
    end
    send_beat(op, mask, stamp, 1'($urandom), ch);
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_EVENT;
    in_ch.pin_mask  = '0;
    in_ch.now_ms    = '0;
    in_ch.pin_level = 1'b0;
    in_ch.channel   = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_LOCKOUT;
    cfg_ch.data     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers: lockout 2, blocked when high, masks 4/2/1
    set_idling(IDLE_NONE);
    send_beat(OP_EVENT, 16'h0004, 32'd1, 1'b1, 8'd0);          // too soon after reset
    send_beat(OP_EVENT, 16'h0004, 32'd2, 1'b1, 8'd0);
    send_beat(OP_EVENT, 16'h0004, 32'd3, 1'b1, 8'd0);          // inside lockout
    send_beat(OP_EVENT, 16'h0008, 32'd50, 1'b1, 8'd0);         // no channel matches
    send_beat(OP_EVENT, 16'h0002, 32'd100, 1'b0, 8'd0);
    send_beat(OP_EVENT, 16'h0001, 32'hFFFF_FFFF, 1'b1, 8'd0);
    send_beat(OP_EVENT, 16'h0001, 32'h0000_0001, 1'b1, 8'd0);  // elapsed across the wrap
    send_beat(OP_LEVEL, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'd0);
    send_beat(OP_LEVEL, '0, '0, 1'b0, 8'd1);
    send_beat(OP_LEVEL, '0, '0, 1'b0, 8'd2);
    send_beat(OP_LEVEL, '0, '0, 1'b0, 8'd3);
    send_beat(OP_LEVEL, '0, '0, 1'b0, 8'd255);
    send_beat(OP_TAKE, '0, '0, 1'b0, 8'd0);
    send_beat(OP_TAKE, '0, '0, 1'b0, 8'd0);
    send_beat(OP_TAKE, '0, '0, 1'b0, 8'd255);
    send_beat(OP_TAKE_LOWEST, '0, '0, 1'b0, 8'd0);
    send_beat(OP_TAKE_LOWEST, '0, '0, 1'b0, 8'd0);
    send_beat(OP_EVENT, 16'h0002, 32'd200, 1'b1, 8'd0);
    send_beat(OP_EVENT, 16'h0002, 32'd300, 1'b0, 8'd0);        // unblocked keeps the latch
    send_beat(OP_TAKE_LOWEST, '0, '0, 1'b0, 8'd0);
    settle();

    write_reg(REG_PIN0, 16'hFFFF);
    write_reg(REG_PIN1, 16'hFFFF);
    write_reg(REG_PIN2, 16'h0000);
    write_reg(REG_POLARITY, 16'h0000);
    write_reg(REG_LOCKOUT, 16'h0000);
    write_reg(RegSpare, 16'hFFFF);                              // unmapped, ignored
    settings_used++;
    send_beat(OP_EVENT, 16'hFFFF, 32'd0, 1'b0, 8'd0);
    send_beat(OP_EVENT, 16'h0000, 32'd0, 1'b1, 8'd0);
    send_beat(OP_LEVEL, '0, '0, 1'b0, 8'd0);
    send_beat(OP_TAKE_LOWEST, '0, '0, 1'b0, 8'd0);

    for (int p = 0; p < 8; p++) begin
      settle();
      set_idling(idle_mode_e'(p % 4));
      apply_phase_setting(p);
      clock_ms = $urandom;
      repeat (80) begin
        if ($urandom_range(59) == 0) settle();
        random_beat();
      end
    end
    settle();

    $display("Sent %0d beats over %0d register settings and four idling patterns;",
             beats_sent, settings_used);
    $display("%0d results compared, %0d pin events accepted.", results_checked,
             events_taken);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
